/* rtl/core/tapf_pkg.sv */
package tapf_pkg;
	localparam int MAX_TRACES_DEF = 16;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [6:0] PCT_DEFAULT = 7'd10;
	localparam logic [1:0] REG_REJECT = 2'd0;
	localparam logic [1:0] REG_TYPE = 2'd1;
	localparam logic [1:0] REG_NOISE = 2'd2;
	localparam logic [1:0] FT_SW_MEAN = 2'd0;
	localparam logic [1:0] FT_SW_MEDIAN = 2'd1;
	localparam logic [1:0] FT_MEDIAN = 2'd2;
	localparam logic [1:0] FT_MEAN = 2'd3;
endpackage

/* rtl/core/trimmed_amplitude_panel_filter_top.sv */
// Channel  Dir  Payload
// s_axis   in   tdata: sample_re, sample_im; tuser: is_current; tlast: last_in_slice
// m_axis   out  tdata: result_re, result_im, current_kept
// cfg      in   we, idx, wdata (7 bits)
// A value that does not end a slice is stored in the sample memory while it has room.
// A slice end runs a rank pass that compares each stored value with every stored
// value, then fetches the current value. The mean types then run the two divisions,
// real part first, the median types fetch the median, and a last step forms the result.
// Reset clears the state, counters and output valid and loads the register
// defaults; the other registers and the sample memory hold no reset value.
// A result that is still waiting holds the next slice in its result cycle.
module trimmed_amplitude_panel_filter_top
	import tapf_pkg::*;
#(
	parameter int MAX_TRACES = MAX_TRACES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_re, sample_im
	input  logic s_axis_tuser, // is_current
	input  logic s_axis_tlast, // last_in_slice
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0] m_axis_tdata, // result_re, result_im, kept
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [6:0] cfg_wdata
);
	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(MAX_TRACES);
	localparam int CNTW = $clog2(MAX_TRACES + 1);
	localparam int MW = 2 * SB + 1;
	localparam int SW = SB + AW + 1;
	localparam int DIVB = SW + 1;
	localparam int OW = ((2*SB+1+7)/8)*8;

	localparam logic [3:0] ST_LOAD = 4'd0, ST_RI = 4'd1, ST_RIW = 4'd2, ST_RJ = 4'd3,
		ST_RJW = 4'd4, ST_CUR = 4'd5, ST_CURW = 4'd6, ST_DIVR = 4'd7, ST_DIVI = 4'd8,
		ST_OUT = 4'd9, ST_MED = 4'd10, ST_MEDW = 4'd11, ST_HOLD = 4'd12;

	logic [6:0] rej_q;
	logic [1:0] ftype_q;
	logic       noise_q;
	logic [3:0] st_q;
	logic [CNTW-1:0] cnt_q, nkeep_q;
	logic [AW-1:0] cur_q, i_q, j_q, med_q;
	logic [CNTW-1:0] rank_q;
	logic [MW-1:0] magi_q;
	logic signed [SB-1:0] vi_re_q, vi_im_q, cur_re_q, cur_im_q, est_re_q, est_im_q;
	logic signed [SW-1:0] sum_re_q, sum_im_q;
	logic cur_kept_q;
	logic [OW-1:0] out_q;
	logic ovalid_q;

	logic we;
	logic [AW-1:0] raddr;
	logic [2*SB-1:0] rdata;
	logic signed [SB-1:0] rd_re, rd_im;
	logic [SB-1:0] ar, ai;
	logic [MW-1:0] magr;

	assign rd_re = rdata[SB-1:0];
	assign rd_im = rdata[2*SB-1:SB];
	assign ar = rd_re[SB-1] ? SB'(-rd_re) : rd_re;
	assign ai = rd_im[SB-1] ? SB'(-rd_im) : rd_im;
	assign magr = MW'(ar * ar) + MW'(ai * ai);

	assign s_axis_tready = (st_q == ST_LOAD);
	assign we = s_axis_tvalid && s_axis_tready && (cnt_q < CNTW'(MAX_TRACES));

	tapf_ram #(.WIDTH(2*SB), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(we), .waddr(cnt_q[AW-1:0]), .wdata(s_axis_tdata[2*SB-1:0]),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		case (st_q)
			ST_RI: raddr = i_q;
			ST_RJ: raddr = j_q;
			ST_CUR: raddr = cur_q;
			ST_MED: raddr = med_q;
			default: raddr = i_q;
		endcase
	end

	// keep count
	// The division by 100 is a multiplication by a rounded-up reciprocal, exact
	// for every product below about 43000.
	localparam int KSH = 19;
	localparam int KMUL = ((1 << KSH) + 99) / 100;
	logic [6:0] rej_eff;
	logic [CNTW+7:0] kprod;
	logic [CNTW+20:0] kscaled;
	logic [CNTW-1:0] kraw;
	assign rej_eff = (rej_q == 7'd0 || rej_q > PCT_FULL) ? PCT_DEFAULT : rej_q;
	assign kprod = (CNTW+8)'(cnt_q) * (CNTW+8)'(PCT_FULL - rej_eff) + (CNTW+8)'(50);
	assign kscaled = (CNTW+21)'(kprod) * (CNTW+21)'(KMUL);
	assign kraw = CNTW'(kscaled >> KSH);

	// divider
	logic div_start, div_done;
	logic [DIVB-1:0] div_num, div_quo;
	logic signed [SW-1:0] div_sum;
	logic [SW-1:0] div_mag;
	assign div_sum = (st_q == ST_DIVI) ? sum_im_q : sum_re_q;
	assign div_mag = div_sum[SW-1] ? SW'(-div_sum) : div_sum;
	assign div_num = {1'b0, div_mag} + DIVB'(nkeep_q >> 1);
	logic go_q;
	assign div_start = go_q;
	tapf_div #(.NBITS(DIVB), .DBITS(CNTW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(nkeep_q), .done(div_done), .quo(div_quo)
	);
	logic signed [SB-1:0] div_res;
	assign div_res = div_sum[SW-1] ? SB'(-div_quo) : SB'(div_quo);

	logic signed [SB:0] nre, nim;
	logic signed [SB-1:0] fre, fim, sre, sim;
	localparam logic signed [SB:0] SMAX = (SB+1)'((1 << (SB-1)) - 1);
	localparam logic signed [SB:0] SMIN = -SMAX - 1;
	always_comb begin
		fre = est_re_q;
		fim = est_im_q;
		if ((ftype_q == FT_SW_MEAN || ftype_q == FT_SW_MEDIAN) && cur_kept_q) begin
			fre = cur_re_q;
			fim = cur_im_q;
		end
		nre = (SB+1)'(cur_re_q) - (SB+1)'(fre);
		nim = (SB+1)'(cur_im_q) - (SB+1)'(fim);
		sre = (nre > SMAX) ? SMAX[SB-1:0] : (nre < SMIN) ? SMIN[SB-1:0] : nre[SB-1:0];
		sim = (nim > SMAX) ? SMAX[SB-1:0] : (nim < SMIN) ? SMIN[SB-1:0] : nim[SB-1:0];
		if (noise_q) begin
			fre = sre;
			fim = sim;
		end
	end

	logic is_med;
	assign is_med = (ftype_q == FT_SW_MEDIAN || ftype_q == FT_MEDIAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q <= PCT_DEFAULT;
			ftype_q <= FT_SW_MEAN;
			noise_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REJECT: rej_q <= cfg_wdata;
				REG_TYPE: ftype_q <= cfg_wdata[1:0];
				REG_NOISE: noise_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			cur_q <= '0;
			ovalid_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (ovalid_q && m_axis_tready && st_q != ST_OUT) ovalid_q <= 1'b0;
			case (st_q)
				ST_LOAD: if (s_axis_tvalid) begin
					if (we) begin
						cnt_q <= cnt_q + 1'b1;
						if (s_axis_tuser) cur_q <= cnt_q[AW-1:0];
					end
					if (s_axis_tlast) begin
						st_q <= ST_RI;
						i_q <= '0;
						sum_re_q <= '0;
						sum_im_q <= '0;
						cur_kept_q <= 1'b0;
						med_q <= '0;
					end
				end
				ST_RI: begin
					nkeep_q <= (kraw == '0) ? CNTW'(1) : (kraw > cnt_q) ? cnt_q : kraw;
					st_q <= ST_RIW;
				end
				ST_RIW: begin
					magi_q <= magr;
					vi_re_q <= rd_re;
					vi_im_q <= rd_im;
					rank_q <= '0;
					j_q <= '0;
					st_q <= ST_RJ;
				end
				ST_RJ: st_q <= ST_RJW;
				ST_RJW: begin
					logic [CNTW-1:0] rk;
					rk = rank_q;
					if (magr < magi_q || (magr == magi_q && j_q < i_q)) rk = rank_q + 1'b1;
					rank_q <= rk;
					if (CNTW'(j_q) + 1'b1 == cnt_q) begin
						if (rk < nkeep_q) begin
							sum_re_q <= sum_re_q + SW'(vi_re_q);
							sum_im_q <= sum_im_q + SW'(vi_im_q);
							if (i_q == cur_q) cur_kept_q <= 1'b1;
						end
						if (rk == (nkeep_q >> 1)) med_q <= i_q;
						if (CNTW'(i_q) + 1'b1 == cnt_q) st_q <= ST_CUR;
						else begin
							i_q <= i_q + 1'b1;
							st_q <= ST_RI;
						end
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= ST_RJ;
					end
				end
				ST_CUR: st_q <= ST_CURW;
				ST_CURW: begin
					cur_re_q <= rd_re;
					cur_im_q <= rd_im;
					if (is_med) st_q <= ST_MED;
					else begin
						st_q <= ST_DIVR;
						go_q <= 1'b1;
					end
				end
				ST_MED: st_q <= ST_MEDW;
				ST_MEDW: begin
					est_re_q <= rd_re;
					est_im_q <= rd_im;
					st_q <= ST_OUT;
				end
				ST_DIVR: if (div_done) begin
					est_re_q <= div_res;
					st_q <= ST_DIVI;
					go_q <= 1'b1;
				end
				ST_DIVI: if (div_done) begin
					est_im_q <= div_res;
					st_q <= ST_OUT;
				end
				ST_OUT: if (!ovalid_q || m_axis_tready) begin
					out_q <= OW'({cur_kept_q, fim, fre});
					ovalid_q <= 1'b1;
					cnt_q <= '0;
					cur_q <= '0;
					st_q <= ST_LOAD;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;
endmodule

/* rtl/core/tapf_ram.sv */
module tapf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/tapf_div.sv */
// Restoring divider of a magnitude by a small count, one quotient bit a cycle.
module tapf_div #(
	parameter int NBITS = 32,
	parameter int DBITS = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NBITS-1:0] num,
	input  logic [DBITS-1:0] den,
	output logic             done,
	output logic [NBITS-1:0] quo
);
	localparam int CW = $clog2(NBITS + 1);
	logic [NBITS-1:0] q_q;
	logic [DBITS:0]   r_q;
	logic [DBITS-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DBITS+1:0] trial;

	assign trial = {r_q, q_q[NBITS-1]} - {2'b00, d_q};
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[DBITS+1]) begin
				r_q <= trial[DBITS:0];
				q_q <= {q_q[NBITS-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DBITS-1:0], q_q[NBITS-1]};
				q_q <= {q_q[NBITS-2:0], 1'b0};
			end
		end
	end
endmodule

/* verif/tb_trimmed_amplitude_panel_filter_top.sv */
module tb_trimmed_amplitude_panel_filter_top;
	import tapf_pkg::*;

	localparam int NTR = MAX_TRACES_DEF;
	localparam int SB = SAMPLE_BITS_DEF;
	localparam int IW = ((2*SB+7)/8)*8;
	localparam int OW = ((2*SB+1+7)/8)*8;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = NTR*(2*NTR + 2) + 2 + 2*(SB + $clog2(NTR) + 4) + 20;

	typedef logic signed [SB-1:0] samp_t;
	typedef struct packed {
		logic kept;
		samp_t im;
		samp_t re;
	} slice_result_t;

	class slice_scoreboard;
		samp_t panel_re[NTR];
		samp_t panel_im[NTR];
		int loaded;
		int cur;
		logic [6:0] reject;
		logic [1:0] ftype;
		logic noise;
		slice_result_t pending[$];
		int errors;
		int slices;

		function void clear();
			loaded = 0;
			cur = 0;
			reject = PCT_DEFAULT;
			ftype = FT_SW_MEAN;
			noise = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [6:0] val);
			case (idx)
				REG_REJECT: reject = val;
				REG_TYPE: ftype = val[1:0];
				REG_NOISE: noise = val[0];
				default: ;
			endcase
		endfunction

		function longint round_div(longint sum, longint n);
			longint q;
			q = ((sum < 0 ? -sum : sum) + n/2) / n;
			return sum < 0 ? -q : q;
		endfunction

		function longint clip(longint v);
			longint hi;
			hi = (longint'(1) <<< (SB-1)) - 1;
			if (v > hi) return hi;
			if (v < -hi-1) return -hi-1;
			return v;
		endfunction

		function void note_sample(samp_t re, samp_t im, logic is_cur, logic last);
			longint mag[NTR];
			int rnk[NTR];
			int rej, nkeep, med;
			longint sre, sim, ere, eim, cre, cim;
			logic ck;
			slice_result_t r;
			if (loaded < NTR) begin
				panel_re[loaded] = re;
				panel_im[loaded] = im;
				if (is_cur) cur = loaded;
				loaded++;
			end
			if (!last) return;
			rej = reject;
			if (rej == 0 || rej > 100) rej = PCT_DEFAULT;
			nkeep = (loaded * (100 - rej) + 50) / 100;
			if (nkeep < 1) nkeep = 1;
			if (nkeep > loaded) nkeep = loaded;
			sre = 0;
			sim = 0;
			med = 0;
			for (int i = 0; i < loaded; i++)
				mag[i] = longint'(panel_re[i])*panel_re[i] + longint'(panel_im[i])*panel_im[i];
			for (int i = 0; i < loaded; i++) begin
				rnk[i] = 0;
				for (int j = 0; j < loaded; j++)
					if (mag[j] < mag[i] || (mag[j] == mag[i] && j < i)) rnk[i]++;
				if (rnk[i] < nkeep) begin
					sre += panel_re[i];
					sim += panel_im[i];
				end
				if (rnk[i] == nkeep/2) med = i;
			end
			cre = panel_re[cur];
			cim = panel_im[cur];
			ck = rnk[cur] < nkeep;
			if (ftype == FT_SW_MEDIAN || ftype == FT_MEDIAN) begin
				ere = panel_re[med];
				eim = panel_im[med];
			end else begin
				ere = round_div(sre, nkeep);
				eim = round_div(sim, nkeep);
			end
			if ((ftype == FT_SW_MEAN || ftype == FT_SW_MEDIAN) && ck) begin
				ere = cre;
				eim = cim;
			end
			if (noise) begin
				ere = clip(cre - ere);
				eim = clip(cim - eim);
			end
			r.re = samp_t'(ere);
			r.im = samp_t'(eim);
			r.kept = ck;
			pending.push_back(r);
			loaded = 0;
			cur = 0;
		endfunction

		function void check_result(logic [OW-1:0] d);
			slice_result_t exp_r, got;
			got = slice_result_t'(d[2*SB:0]);
			if (pending.size() == 0) begin
				$error("unexpected result re=%0d im=%0d", got.re, got.im);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			slices++;
			if (got.re !== exp_r.re) begin
				$error("result_re expected %0d got %0d", exp_r.re, got.re);
				errors++;
			end
			if (got.im !== exp_r.im) begin
				$error("result_im expected %0d got %0d", exp_r.im, got.im);
				errors++;
			end
			if (got.kept !== exp_r.kept) begin
				$error("current_kept expected %0d got %0d", exp_r.kept, got.kept);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IW-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OW-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [6:0] cfg_wdata = '0;

	slice_scoreboard board;
	int idle_cycles = 0;
	int sent = 0;
	int burst_left = 0;
	bit hold_off = 1'b0;
	bit hold_done = 1'b0;

	trimmed_amplitude_panel_filter_top uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				board.note_sample(samp_t'(s_axis_tdata[SB-1:0]), samp_t'(s_axis_tdata[2*SB-1:SB]),
					s_axis_tuser, s_axis_tlast);
				sent++;
			end
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL trimmed_amplitude_panel_filter_top");
				$finish;
			end
		end
	end

	// Receiver stall pattern, with one long hold-off while the sender keeps offering.
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (sent < 200 || sent > 900)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		wait (sent >= 300);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
		hold_done = 1'b1;
	end

	task automatic send_sample(samp_t re, samp_t im, logic is_cur, logic last, bit gaps);
		if (gaps) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 6)) begin
					@(negedge clk);
					s_axis_tvalid <= 1'b0;
				end
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IW-2*SB){1'b0}}, im, re};
		s_axis_tuser <= is_cur;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic samp_t rand_samp(int mode);
		case (mode)
			0: return samp_t'($urandom);
			1: return samp_t'($urandom_range(0, 200)) - samp_t'(100);
			2: return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
			default: return samp_t'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_slice(int n, bit gaps);
		int mode;
		int cur_pos;
		mode = $urandom_range(0, 3);
		cur_pos = $urandom_range(0, n);
		for (int i = 0; i < n; i++)
			send_sample(rand_samp(mode), rand_samp(mode),
				(i == cur_pos) || ($urandom_range(0, 15) == 0), i == n-1, gaps);
	endtask

	logic [6:0] rej_choices[8] = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd50, 7'd10, 7'd33, 7'd99};

	initial begin
		board = new();
		board.clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every type, single-value slice, overfull panel.
		for (int t = 0; t < 4; t++) begin
			write_reg(REG_TYPE, 7'(t));
			write_reg(REG_NOISE, 7'(t & 1));
			send_sample({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0, 1'b0, 1'b0);
			send_sample({1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}}, 1'b1, 1'b0, 1'b0);
			send_sample(samp_t'(-1), samp_t'(1), 1'b0, 1'b1, 1'b0);
			drain();
		end
		write_reg(REG_REJECT, 7'd100);
		send_sample(samp_t'(5), samp_t'(-5), 1'b0, 1'b1, 1'b0);
		for (int i = 0; i < NTR + 3; i++)
			send_sample(samp_t'(i % 3), samp_t'(-(i % 3)), i == NTR + 1, i == NTR + 2, 1'b0);
		drain();

		// Random slices across register settings.
		while (sent < 1000) begin
			write_reg(REG_REJECT, rej_choices[$urandom_range(0, 7)]);
			write_reg(REG_TYPE, 7'($urandom_range(0, 3)));
			write_reg(REG_NOISE, 7'($urandom_range(0, 1)));
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) == 0) send_slice(NTR + $urandom_range(1, 4), 1'b1);
				else send_slice($urandom_range(1, NTR), $urandom_range(0, 3) != 0);
			end
			drain();
		end
		wait (hold_done);
		drain();
		$display("Covered %0d items and %0d slices over all filter types, noise modes",
			sent, board.slices);
		$display("and reject settings including out-of-range values and overfull panels.");
		if (board.errors == 0)
			$display("PASS trimmed_amplitude_panel_filter_top");
		else
			$display("FAIL trimmed_amplitude_panel_filter_top");
		$finish;
	end
endmodule
